### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers for the blur core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define BBR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every rising clock edge, reset included
`define BBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg
// Types and constants shared by the 3x3 region box blur core
// ----------------------------------------------------------------------------
package bbr_pkg;

  // index widths, wide enough for the largest supported frame
  localparam int unsigned COL_W = 6;
  localparam int unsigned ROW_W = 16;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // reciprocals for the divisors 4, 6 and 9, scaled by 2^23
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [21:0] RECIP_4 = 22'd2097152;
  localparam logic [21:0] RECIP_6 = 22'd1398102;
  localparam logic [21:0] RECIP_9 = 22'd932068;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_IMAGE_ROWS       = 3'd0,
    REG_IMAGE_COLS       = 3'd1,
    REG_REGION_ROW_FIRST = 3'd2,
    REG_REGION_COL_FIRST = 3'd3,
    REG_REGION_ROW_FINAL = 3'd4,
    REG_REGION_COL_FINAL = 3'd5,
    REG_SPARE_6          = 3'd6,
    REG_SPARE_7          = 3'd7
  } reg_idx_e;

  // back end sequencer
  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_DRAIN,
    B_SCALE,
    B_MUL,
    B_OUT
  } back_state_e;

  // one classified sample on its way to the back end
  typedef struct packed {
    logic signed [15:0] sample;
    logic [COL_W-1:0]   col;
    logic [1:0]         rot;
    logic [ROW_W-1:0]   row;
    logic               row_end;
    logic               last_row;
  } q_item_t;

  // frame geometry as seen by the back end
  typedef struct packed {
    logic [COL_W-1:0] ncols;
    logic [9:0]       row_first;
    logic [4:0]       col_first;
    logic [9:0]       row_final;
    logic [4:0]       col_final;
  } geom_t;

endpackage

### rtl/core/bbr_smp_if.sv
// ----------------------------------------------------------------------------
// bbr_smp_if
// Sample input channel, valid/ready with one Q8.8 sample per item
// ----------------------------------------------------------------------------
interface bbr_smp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### rtl/core/bbr_pix_if.sv
// ----------------------------------------------------------------------------
// bbr_pix_if
// Pixel output channel, valid/ready with pixel and burst markers
// ----------------------------------------------------------------------------
interface bbr_pix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_out;
  logic               run_last;
  logic               frame_last;

  modport source (output valid, output pixel_out, output run_last, output frame_last,
                  input ready);
  modport sink (input valid, input pixel_out, input run_last, input frame_last,
                output ready);
endinterface

### rtl/core/box_blur_3x3_region.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_region
// 3x3 rounded box mean over a region of interest in a raster sample stream
// ----------------------------------------------------------------------------
// Samples enter a short queue at one per cycle while it has room; the back end
// takes one queued sample per cycle into the line store while it is idle. A row
// end releases a burst of results for the row above (two rows on the last row of
// a frame). Each result pixel passes through the back end as nine neighbourhood
// reads through the single read port of the line store, then drain, scale,
// multiply and output; the back end takes no new sample until the burst is done.
// The line store needs no clearing pass after reset.
module box_blur_3x3_region
  import bbr_pkg::*;
#(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bbr_smp_if.sink     sample_i,
  bbr_pix_if.source   pixel_o
);

  q_item_t push_item, pop_item;
  logic    push_valid, push_ready, pop_valid, pop_ready;
  geom_t   geom;

  // front: registers and classification
  bbr_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .smp          (sample_i),
    .item_o       (push_item),
    .item_valid_o (push_valid),
    .item_ready_i (push_ready),
    .geom_o       (geom)
  );

  // decoupling queue
  bbr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  // back: line store and mean
  bbr_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (pop_item),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .geom_i       (geom),
    .pix          (pixel_o)
  );

endmodule

### rtl/core/bbr_front.sv
// ----------------------------------------------------------------------------
// bbr_front
// Configuration registers, raster position tracking and item classification
// ----------------------------------------------------------------------------
module bbr_front
  import bbr_pkg::*;
#(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bbr_smp_if.sink     smp,
  output q_item_t     item_o,
  output logic        item_valid_o,
  input  logic        item_ready_i,
  output geom_t       geom_o
);

  logic [10:0]      image_rows_q;
  logic [5:0]       image_cols_q;
  logic [9:0]       row_first_q;
  logic [4:0]       col_first_q;
  logic [9:0]       row_final_q;
  logic [4:0]       col_final_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [1:0]       rot_q, rot_d;
  logic [16:0]      rows_ext, rows_clamp;
  logic [6:0]       cols_ext, cols_clamp;
  logic [ROW_W-1:0] nrows;
  logic [COL_W-1:0] ncols;
  logic             cfg_wr, push, row_end, last_row, reg_hit;
  reg_idx_e         idx;

  localparam logic [16:0] MaxRows = 17'(MAX_ROWS);
  localparam logic [6:0]  MaxCols = 7'(MAX_COLS);

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite;

  // effective frame size
  always_comb begin
    rows_ext   = 17'(image_rows_q);
    cols_ext   = 7'(image_cols_q);
    rows_clamp = (rows_ext < 17'd2) ? 17'd2 : ((rows_ext > MaxRows) ? MaxRows : rows_ext);
    cols_clamp = (cols_ext < 7'd2) ? 7'd2 : ((cols_ext > MaxCols) ? MaxCols : cols_ext);
    nrows      = ROW_W'(rows_clamp);
    ncols      = COL_W'(cols_clamp);
  end

  // register readback
  always_comb begin
    unique case (idx)
      REG_IMAGE_ROWS:       prdata = 32'(image_rows_q);
      REG_IMAGE_COLS:       prdata = 32'(image_cols_q);
      REG_REGION_ROW_FIRST: prdata = 32'(row_first_q);
      REG_REGION_COL_FIRST: prdata = 32'(col_first_q);
      REG_REGION_ROW_FINAL: prdata = 32'(row_final_q);
      REG_REGION_COL_FINAL: prdata = 32'(col_final_q);
      default:              prdata = 32'd0;
    endcase
  end

  always_comb begin
    unique case (idx)
      REG_SPARE_6, REG_SPARE_7: reg_hit = 1'b0;
      default:                  reg_hit = 1'b1;
    endcase
  end

  // classify the incoming item
  assign smp.ready    = item_ready_i;
  assign item_valid_o = smp.valid;
  assign push         = smp.valid && item_ready_i;
  assign row_end      = (col_q == ncols - COL_W'(1));
  assign last_row     = (row_q == nrows - ROW_W'(1));

  always_comb begin
    item_o.sample   = smp.sample;
    item_o.col      = col_q;
    item_o.rot      = rot_q;
    item_o.row      = row_q;
    item_o.row_end  = row_end;
    item_o.last_row = last_row;
  end

  // raster position after this item, cleared by a write to a used register
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    rot_d = rot_q;
    if (cfg_wr && reg_hit) begin
      col_d = '0;
      row_d = '0;
      rot_d = '0;
    end else if (push) begin
      if (!row_end) begin
        col_d = col_q + COL_W'(1);
      end else begin
        col_d = '0;
        if (last_row) begin
          row_d = '0;
          rot_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
          rot_d = (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rot_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      rot_q <= rot_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q <= 11'd2;
      image_cols_q <= 6'd2;
      row_first_q  <= '0;
      col_first_q  <= '0;
      row_final_q  <= '0;
      col_final_q  <= '0;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_IMAGE_ROWS:       image_rows_q <= pwdata[10:0];
        REG_IMAGE_COLS:       image_cols_q <= pwdata[5:0];
        REG_REGION_ROW_FIRST: row_first_q  <= pwdata[9:0];
        REG_REGION_COL_FIRST: col_first_q  <= pwdata[4:0];
        REG_REGION_ROW_FINAL: row_final_q  <= pwdata[9:0];
        REG_REGION_COL_FINAL: col_final_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom_o.ncols     = ncols;
    geom_o.row_first = row_first_q;
    geom_o.col_first = col_first_q;
    geom_o.row_final = row_final_q;
    geom_o.col_final = col_final_q;
  end

endmodule

### rtl/core/bbr_queue.sv
// ----------------------------------------------------------------------------
// bbr_queue
// Short item queue that decouples the front from the back
// ----------------------------------------------------------------------------
module bbr_queue
  import bbr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_item_t push_item_i,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  output q_item_t pop_item_o,
  output logic    pop_valid_o,
  input  logic    pop_ready_i
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  q_item_t       slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slot_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + PW'(1);
      if (pop) rptr_q <= rptr_q + PW'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

endmodule

### rtl/core/bbr_back.sv
// ----------------------------------------------------------------------------
// bbr_back
// Line store, neighbourhood gather, rounded mean and result output
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbr_back
  import bbr_pkg::*;
#(
  parameter int unsigned MAX_COLS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_item_t   item_i,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  geom_t     geom_i,
  bbr_pix_if.source pix
);

  localparam int unsigned AW = $clog2(3 * MAX_COLS);

  back_state_e        state_q, state_d;
  logic signed [15:0] mem_q [3 * MAX_COLS];
  logic signed [15:0] rd_q, center_q;
  logic [COL_W-1:0]   j_q;
  logic [1:0]         tr_q, tc_q, cur_q;
  logic [ROW_W-1:0]   row_q;
  logic               phase_q, two_q, acc_vld_q, acc_ctr_q, neg_q;
  logic signed [19:0] sum_q;
  logic [18:0]        x_q;
  logic [21:0]        m_q;
  logic [40:0]        prod_q;

  logic [1:0]         prev, prev2, st_above, st_mid, st_below, tap_st;
  logic               has_above, has_below, col_lo_ok, col_hi_ok;
  logic               tap_row_ok, tap_col_ok, last_tap, last_col, in_region;
  logic [COL_W-1:0]   tap_col;
  logic [ROW_W-1:0]   erow;
  logic [AW-1:0]      waddr, raddr;
  logic               pop, we, start;
  logic [19:0]        abs_sum;
  logic [2:0]         half;
  logic [21:0]        recip;
  logic [16:0]        quot;
  logic [15:0]        mean;

  // stores of the row being emitted and its neighbours
  always_comb begin
    prev  = (cur_q == 2'd0) ? 2'd2 : cur_q - 2'd1;
    prev2 = (cur_q == 2'd2) ? 2'd0 : cur_q + 2'd1;
    if (!phase_q) begin
      st_above  = prev2;
      st_mid    = prev;
      st_below  = cur_q;
      has_above = (row_q >= ROW_W'(2));
      has_below = 1'b1;
      erow      = row_q - ROW_W'(1);
    end else begin
      st_above  = prev;
      st_mid    = cur_q;
      st_below  = cur_q;
      has_above = 1'b1;
      has_below = 1'b0;
      erow      = row_q;
    end
  end

  assign col_lo_ok = (j_q != '0);
  assign last_col  = (j_q == geom_i.ncols - COL_W'(1));
  assign col_hi_ok = !last_col;
  assign last_tap  = (tr_q == 2'd2) && (tc_q == 2'd2);
  assign in_region = (erow >= ROW_W'(geom_i.row_first)) && (erow <= ROW_W'(geom_i.row_final))
                  && (j_q >= COL_W'(geom_i.col_first)) && (j_q <= COL_W'(geom_i.col_final));

  // tap address, invalid taps fall back to the centre row or column
  always_comb begin
    tap_row_ok = (tr_q == 2'd1) || (tr_q == 2'd0 && has_above) || (tr_q == 2'd2 && has_below);
    tap_col_ok = (tc_q == 2'd1) || (tc_q == 2'd0 && col_lo_ok) || (tc_q == 2'd2 && col_hi_ok);
    tap_st     = !tap_row_ok ? st_mid : ((tr_q == 2'd0) ? st_above :
                                         ((tr_q == 2'd1) ? st_mid : st_below));
    tap_col    = !tap_col_ok ? j_q : ((tc_q == 2'd0) ? j_q - COL_W'(1) :
                                      ((tc_q == 2'd1) ? j_q : j_q + COL_W'(1)));
    raddr      = AW'(tap_st) * AW'(MAX_COLS) + AW'(tap_col);
    waddr      = AW'(item_i.rot) * AW'(MAX_COLS) + AW'(item_i.col);
  end

  // divisor from the neighbourhood shape
  always_comb begin
    if (has_above && has_below && col_lo_ok && col_hi_ok) begin
      half  = 3'd4;
      recip = RECIP_9;
    end else if ((has_above && has_below) || (col_lo_ok && col_hi_ok)) begin
      half  = 3'd3;
      recip = RECIP_6;
    end else begin
      half  = 3'd2;
      recip = RECIP_4;
    end
    abs_sum = sum_q[19] ? 20'(-sum_q) : 20'(sum_q);
    quot    = 17'(prod_q >> RECIP_SHIFT);
    mean    = neg_q ? 16'(-quot) : 16'(quot);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (item_valid_i && item_i.row_end && (item_i.row != '0)) state_d = B_READ;
      end
      B_READ:  if (last_tap) state_d = B_DRAIN;
      B_DRAIN: state_d = B_SCALE;
      B_SCALE: state_d = B_MUL;
      B_MUL:   state_d = B_OUT;
      B_OUT: begin
        if (pix.ready) begin
          if (!last_col || (!phase_q && two_q)) state_d = B_READ;
          else state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready_o   = 1'b0;
    pix.valid      = 1'b0;
    unique case (state_q)
      B_IDLE:  item_ready_o = 1'b1;
      B_OUT:   pix.valid    = 1'b1;
      default: ;
    endcase
    pix.pixel_out  = in_region ? signed'(mean) : center_q;
    pix.run_last   = last_col && (phase_q || !two_q);
    pix.frame_last = last_col && phase_q;
  end

  assign pop   = item_valid_i && item_ready_o;
  assign we    = pop;
  assign start = (state_q == B_OUT) && pix.ready && (state_d == B_READ);

  // line store
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= item_i.sample;
    rd_q <= mem_q[raddr];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (acc_ctr_q) center_q <= rd_q;
    if (state_q == B_SCALE) begin
      neg_q <= sum_q[19];
      x_q   <= 19'(abs_sum) + 19'(half);
      m_q   <= recip;
    end
    if (state_q == B_MUL) prod_q <= 41'(x_q) * 41'(m_q);
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      j_q       <= '0;
      tr_q      <= '0;
      tc_q      <= '0;
      cur_q     <= '0;
      row_q     <= '0;
      phase_q   <= 1'b0;
      two_q     <= 1'b0;
      acc_vld_q <= 1'b0;
      acc_ctr_q <= 1'b0;
      sum_q     <= '0;
    end else begin
      state_q   <= state_d;
      acc_vld_q <= (state_q == B_READ) && tap_row_ok && tap_col_ok;
      acc_ctr_q <= (state_q == B_READ) && (tr_q == 2'd1) && (tc_q == 2'd1);
      if (acc_vld_q) sum_q <= sum_q + 20'(rd_q);
      // take a row end item
      if (pop && item_i.row_end && (item_i.row != '0)) begin
        cur_q   <= item_i.rot;
        row_q   <= item_i.row;
        two_q   <= item_i.last_row;
        phase_q <= 1'b0;
        j_q     <= '0;
        tr_q    <= '0;
        tc_q    <= '0;
        sum_q   <= '0;
      end
      // step through the nine taps
      if (state_q == B_READ) begin
        if (tc_q == 2'd2) begin
          tc_q <= 2'd0;
          tr_q <= tr_q + 2'd1;
        end else begin
          tc_q <= tc_q + 2'd1;
        end
      end
      // next pixel or next row of the burst
      if (start) begin
        tr_q  <= '0;
        tc_q  <= '0;
        sum_q <= '0;
        if (last_col) begin
          phase_q <= 1'b1;
          j_q     <= '0;
        end else begin
          j_q <= j_q + COL_W'(1);
        end
      end
    end
  end

  `BBR_ASSERT(a_frame_last_ends_run, clk_i, rst_ni, pix.valid && pix.frame_last |-> pix.run_last, "frame end without run end")
  `BBR_ASSERT(a_read_then_drain, clk_i, rst_ni, (state_q == B_READ) && last_tap |=> state_q == B_DRAIN, "tap sweep did not drain")
  `BBR_ASSERT(a_acc_after_read, clk_i, rst_ni, acc_vld_q |-> $past(state_q == B_READ), "accumulate outside tap sweep")

endmodule

### verif/box_blur_3x3_region_test.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_region_test
// Streams frames of random Q8.8 samples through the region box blur, predicts
// every output pixel with its own line-buffer model and checks them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_blur_3x3_region_test
  import bbr_pkg::*;
();

  localparam int MAXC = 32;
  localparam int MAXR = 1024;
  localparam longint CYCLE_LIMIT = 2000000;

  // expected output pixel
  typedef struct {
    logic signed [15:0] pix;
    logic               run_end;
    logic               frame_end;
  } blur_pix_t;

  // blur predictor and queue of pending pixels
  class blur_scoreboard;
    logic signed [15:0] rows_buf [3][MAXC];
    int unsigned        cur_row, cur_col, rot;
    int unsigned        rows_cfg, cols_cfg, rf, cf, rl, cl;
    blur_pix_t          pending[$];
    int                 errors;
    int                 checked;

    function void restart();
      cur_row = 0; cur_col = 0; rot = 0;
    endfunction

    function void set_reg(reg_idx_e idx, int unsigned val);
      case (idx)
        REG_IMAGE_ROWS:       rows_cfg = val & 'h7ff;
        REG_IMAGE_COLS:       cols_cfg = val & 'h3f;
        REG_REGION_ROW_FIRST: rf = val & 'h3ff;
        REG_REGION_COL_FIRST: cf = val & 'h1f;
        REG_REGION_ROW_FINAL: rl = val & 'h3ff;
        REG_REGION_COL_FINAL: cl = val & 'h1f;
        default: return;
      endcase
      restart();
    endfunction

    function int unsigned nrows();
      if (rows_cfg < 2) return 2;
      if (rows_cfg > MAXR) return MAXR;
      return rows_cfg;
    endfunction

    function int unsigned ncols();
      if (cols_cfg < 2) return 2;
      if (cols_cfg > MAXC) return MAXC;
      return cols_cfg;
    endfunction

    function int mean_rounded(int s, int n);
      if (s >= 0) return (s + n / 2) / n;
      return -((-s + n / 2) / n);
    endfunction

    // queue one whole row of pixels
    function void push_row(int unsigned r, int unsigned up, bit has_up,
                           int unsigned mid, int unsigned dn, bit has_dn);
      int unsigned nc, lo, hi;
      int sum, n, v;
      bit in_row;
      blur_pix_t p;
      nc = ncols();
      in_row = (r >= rf) && (r <= rl);
      for (int unsigned j = 0; j < nc; j++) begin
        v = rows_buf[mid][j];
        if (in_row && j >= cf && j <= cl) begin
          lo = (j > 0) ? j - 1 : j;
          hi = (j + 1 < nc) ? j + 1 : j;
          sum = 0; n = 0;
          for (int unsigned c = lo; c <= hi; c++) begin
            if (has_up) begin sum += rows_buf[up][c]; n++; end
            sum += rows_buf[mid][c]; n++;
            if (has_dn) begin sum += rows_buf[dn][c]; n++; end
          end
          v = mean_rounded(sum, n);
        end
        p.pix = v[15:0]; p.run_end = 0; p.frame_end = 0;
        pending.push_back(p);
      end
    endfunction

    // note an accepted sample
    function void note_sample(logic signed [15:0] s);
      int unsigned r, cur, prv, prv2, pend_base;
      pend_base = pending.size();
      if (cur_col >= ncols()) cur_col = 0;
      if (cur_row >= nrows()) cur_row = 0;
      rows_buf[rot][cur_col] = s;
      cur_col++;
      if (cur_col < ncols()) return;
      cur_col = 0;
      r = cur_row; cur = rot; prv = (cur + 2) % 3; prv2 = (cur + 1) % 3;
      if (r >= 1) push_row(r - 1, prv2, r >= 2, prv, cur, 1);
      if (r + 1 >= nrows()) begin
        push_row(r, prv, 1, cur, 0, 0);
        pending[$].frame_end = 1;
        cur_row = 0; rot = 0;
      end else begin
        cur_row = r + 1; rot = (cur + 1) % 3;
      end
      if (pending.size() > pend_base) pending[$].run_end = 1;
    endfunction

    // compare an accepted pixel with the oldest expectation
    function void check_pixel(logic signed [15:0] pix, logic re, logic fe);
      blur_pix_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel %0d run_last %0b frame_last %0b",
                 $time, pix, re, fe);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (pix !== e.pix || re !== e.run_end || fe !== e.frame_end) begin
        $display("%0t: mismatch expected pix %0d run %0b frame %0b, got %0d %0b %0b",
                 $time, e.pix, e.run_end, e.frame_end, pix, re, fe);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bbr_smp_if smp ();
  bbr_pix_if pix ();

  box_blur_3x3_region i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample_i(smp.sink),
    .pixel_o (pix.source)
  );

  blur_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  samples_sent = 0;
  int  frames_done = 0;
  longint cycles = 0;

  always #4 clk_i = ~clk_i;

  initial begin
    smp.valid = 0;
    smp.sample = '0;
    pix.ready = 0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure and checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix.valid && pix.ready)
        sb.check_pixel(pix.pixel_out, pix.run_last, pix.frame_last);
      pix.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // APB write: setup then access
  task automatic reg_write(reg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 5'(int'(idx) * 4); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  // send one sample, with random idle cycles first; valid stays up after
  // the accepting edge so that items can follow back to back
  task automatic send_sample(logic signed [15:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      smp.valid <= 0;
      @(posedge clk_i);
    end
    smp.valid <= 1;
    smp.sample <= s;
    do @(posedge clk_i); while (!smp.ready);
    sb.note_sample(s);
    samples_sent++;
  endtask

  // wait until every expected pixel is out and the back end settles
  task automatic drain();
    smp.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned r, int unsigned c, int unsigned r0,
                           int unsigned c0, int unsigned r1, int unsigned c1);
    drain();
    reg_write(REG_IMAGE_ROWS, r);
    reg_write(REG_IMAGE_COLS, c);
    reg_write(REG_REGION_ROW_FIRST, r0);
    reg_write(REG_REGION_COL_FIRST, c0);
    reg_write(REG_REGION_ROW_FINAL, r1);
    reg_write(REG_REGION_COL_FINAL, c1);
  endtask

  // random sample, biased to extremes now and then
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_sample(pick_sample());
  endtask

  initial begin
    int unsigned r, c;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    send_idle_pct = 19; recv_idle_pct = 71;

    // directed: reset geometry 2x2 with extremes, then a 3x3 fully filtered
    send_sample(16'sh7fff); send_sample(16'sh7fff);
    send_sample(16'sh8000); send_sample(16'sh8000);
    configure(3, 3, 0, 0, 1023, 31);
    send_sample(16'sh7fff); send_sample(16'sh8000); send_sample(16'sh0001);
    send_sample(-16'sd1);   send_sample(16'sh0000); send_sample(16'sh5555);
    send_sample(16'shaaaa); send_sample(16'sh0002); send_sample(-16'sd2);
    // empty region and values below two
    configure(0, 1, 5, 5, 2, 2);
    send_frame(4);
    // region past the image, partial frame then a register write
    configure(2, 4, 1, 3, 900, 30);
    send_frame(3);
    // columns above the line store depth act as the full width
    configure(2, 40, 0, 0, 1023, 31);
    send_frame(64);
    frames_done = 5;

    // random frames, switching idling per phase
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 71; recv_idle_pct = 19; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int f = 0; f < 2; f++) begin
        r = $urandom_range(3, 2);
        c = $urandom_range(3, 2);
        configure(r, c, $urandom_range(3), $urandom_range(5),
                  $urandom_range(3), $urandom_range(31));
        send_frame(r * c);
        frames_done++;
      end
    end
    // tall frame setting, rotation wraps over several rows, upper register bits
    configure(2047, 2, 1022, 0, 1023, 1);
    send_frame(8);
    drain();
    configure(1024, 2, 0, 0, 0, 0);
    drain();

    $display("covered %0d samples over %0d frame setups, %0d pixels checked",
             samples_sent, frames_done + 2, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/bbr_pkg.sv
rtl/core/bbr_smp_if.sv
rtl/core/bbr_pix_if.sv
rtl/core/bbr_front.sv
rtl/core/bbr_queue.sv
rtl/core/bbr_back.sv
rtl/core/box_blur_3x3_region.sv
verif/box_blur_3x3_region_test.sv
